// ===== rtl/mie_pkg.sv =====
// Shared types and constants for the MessagePack item encoder.
// Holds the function codes, result status codes and the command word used by
// the front end, queue and back end, and the back end's sequencing phases.
`timescale 1ns / 1ps
`default_nettype none

package mie_pkg;

  localparam int unsigned FUNC_W     = 4;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned OFFSET_W   = 20;
  localparam int unsigned BUF_SIZE_W = 21;
  localparam int unsigned STR_LEN_W  = 16;

  localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_RESET = 21'd4096;
  localparam logic [BUF_SIZE_W-1:0] BUF_SIZE_MAX   = 21'd1048576;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0] ID_FIXSTR   = 8'hA0;
  localparam logic [7:0] ID_FIXMAP   = 8'h80;
  localparam logic [7:0] ID_FIXARRAY = 8'h90;
  localparam logic [7:0] ID_NIL      = 8'hC0;
  localparam logic [7:0] ID_FALSE    = 8'hC2;
  localparam logic [7:0] ID_TRUE     = 8'hC3;
  localparam logic [7:0] ID_MAP16    = 8'hDE;
  localparam logic [7:0] ID_ARRAY16  = 8'hDC;
  localparam logic [7:0] ID_UINT64   = 8'hCF;
  localparam logic [7:0] ID_INT64    = 8'hD3;
  localparam logic [7:0] ID_FLOAT64  = 8'hCB;
  localparam logic [7:0] ID_STR16    = 8'hDA;

  typedef enum logic [FUNC_W-1:0] {
    FN_RESTART  = 4'd0,
    FN_NIL      = 4'd1,
    FN_FALSE    = 4'd2,
    FN_TRUE     = 4'd3,
    FN_U64      = 4'd4,
    FN_I64      = 4'd5,
    FN_F64      = 4'd6,
    FN_MAP      = 4'd7,
    FN_ARRAY    = 4'd8,
    FN_STR_HDR  = 4'd9,
    FN_STR_BYTE = 4'd10
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_COUNT_BIG = 2'd2,
    ST_NO_STRING = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_RESTART,
    OP_NOP,
    OP_COUNT_ERR,
    OP_EMIT,
    OP_STR_BYTE
  } op_t;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_PAY,
    PH_OPEN_FAIL
  } phase_t;

  // One classified item. The payload is left aligned: byte 0 goes out first.
  typedef struct packed {
    op_t                  op;
    logic [7:0]           id;
    logic                 has_pay;
    logic [2:0]           pay_last;
    logic [VALUE_W-1:0]   pay;
    logic                 is_str;
    logic [STR_LEN_W-1:0] str_len;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/mie_if.sv =====
// Channel interfaces of the MessagePack item encoder: input items,
// result words and the buffer size write port. Widths come from mie_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mie_in_if;
  logic                         valid;
  logic                         ready;
  logic [mie_pkg::FUNC_W-1:0]   func;
  logic [mie_pkg::VALUE_W-1:0]  value;
  logic [mie_pkg::COUNT_W-1:0]  count;
  logic [mie_pkg::DATA_W-1:0]   data_byte;

  modport source (output valid, func, value, count, data_byte, input ready);
  modport sink   (input valid, func, value, count, data_byte, output ready);
endinterface

interface mie_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    out_byte;
  logic [mie_pkg::OFFSET_W-1:0]  out_offset;
  logic                          byte_valid;
  logic [1:0]                    status;
  logic                          is_last;

  modport source (output valid, out_byte, out_offset, byte_valid, status, is_last,
                  input ready);
  modport sink   (input valid, out_byte, out_offset, byte_valid, status, is_last,
                  output ready);
endinterface

interface mie_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mie_pkg::BUF_SIZE_W-1:0]  buffer_size;

  modport source (output valid, buffer_size, input ready);
  modport sink   (input valid, buffer_size, output ready);
endinterface

`default_nettype wire

// ===== rtl/messagepack_item_encoder.sv =====
// MessagePack item encoder: turns each input word into MessagePack bytes for
// a bounded buffer and reports room and count errors. Each result word carries
// at most one byte; an item gives one result word for nil, booleans, fix map
// and array headers, string bytes, restart and errors, two for a fixstr header
// whose body has no room, three for 16-bit headers (four for a str16 whose
// body has no room), nine for 64-bit values; a chunk without room ends the
// item early with a no-room word. The back end produces one result word per
// cycle from its output register unless the output stalls, and this sets the
// rate; items are accepted while earlier ones are still being emitted, and the
// queue between front and back absorbs the difference. An item's first result
// word passes the front end register, a queue entry and the output register.
// The buffer size register may only be written while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module messagepack_item_encoder #(
  parameter int unsigned QUEUE_DEPTH = mie_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mie_in_if.sink    in_chan,
  mie_out_if.source out_chan,
  mie_cfg_if.sink   cfg_chan
);

  logic          f_valid, f_ready;
  mie_pkg::cmd_t f_cmd;
  logic          q_valid, q_ready;
  mie_pkg::cmd_t q_cmd;

  mie_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  mie_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  mie_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_chan  (cfg_chan),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

// ===== rtl/mie_front.sv =====
// Front end of the MessagePack item encoder: accepts input words and
// classifies them into command words for the queue. Uses mie_pkg, mie_if.
`timescale 1ns / 1ps
`default_nettype none

module mie_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  mie_in_if.sink             in_chan,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output mie_pkg::cmd_t      cmd
);

  logic          valid_r;
  mie_pkg::cmd_t cmd_r;
  mie_pkg::cmd_t cmd_nxt;
  logic          cnt_big;
  logic [mie_pkg::STR_LEN_W-1:0] cnt16;
  logic          take;

  assign in_chan.ready = !valid_r || cmd_ready;
  assign take          = in_chan.valid && in_chan.ready;
  assign cnt_big       = |in_chan.count[mie_pkg::COUNT_W-1:mie_pkg::STR_LEN_W];
  assign cnt16         = in_chan.count[mie_pkg::STR_LEN_W-1:0];

  always_comb begin
    cmd_nxt          = '0;
    cmd_nxt.op       = mie_pkg::OP_NOP;
    cmd_nxt.str_len  = cnt16;
    unique case (in_chan.func)
      mie_pkg::FN_RESTART: begin
        cmd_nxt.op = mie_pkg::OP_RESTART;
      end
      mie_pkg::FN_NIL: begin
        cmd_nxt.op = mie_pkg::OP_EMIT;
        cmd_nxt.id = mie_pkg::ID_NIL;
      end
      mie_pkg::FN_FALSE: begin
        cmd_nxt.op = mie_pkg::OP_EMIT;
        cmd_nxt.id = mie_pkg::ID_FALSE;
      end
      mie_pkg::FN_TRUE: begin
        cmd_nxt.op = mie_pkg::OP_EMIT;
        cmd_nxt.id = mie_pkg::ID_TRUE;
      end
      mie_pkg::FN_U64, mie_pkg::FN_I64, mie_pkg::FN_F64: begin
        cmd_nxt.op       = mie_pkg::OP_EMIT;
        cmd_nxt.has_pay  = 1'b1;
        cmd_nxt.pay_last = 3'd7;
        cmd_nxt.pay      = in_chan.value;
        if (in_chan.func == mie_pkg::FN_U64) begin
          cmd_nxt.id = mie_pkg::ID_UINT64;
        end else if (in_chan.func == mie_pkg::FN_I64) begin
          cmd_nxt.id = mie_pkg::ID_INT64;
        end else begin
          cmd_nxt.id = mie_pkg::ID_FLOAT64;
        end
      end
      mie_pkg::FN_MAP, mie_pkg::FN_ARRAY: begin
        if (cnt_big) begin
          cmd_nxt.op = mie_pkg::OP_COUNT_ERR;
        end else if (cnt16 <= 16'd15) begin
          cmd_nxt.op = mie_pkg::OP_EMIT;
          cmd_nxt.id = ((in_chan.func == mie_pkg::FN_MAP) ? mie_pkg::ID_FIXMAP
                                                         : mie_pkg::ID_FIXARRAY)
                       | {4'd0, cnt16[3:0]};
        end else begin
          cmd_nxt.op       = mie_pkg::OP_EMIT;
          cmd_nxt.id       = (in_chan.func == mie_pkg::FN_MAP) ? mie_pkg::ID_MAP16
                                                              : mie_pkg::ID_ARRAY16;
          cmd_nxt.has_pay  = 1'b1;
          cmd_nxt.pay_last = 3'd1;
          cmd_nxt.pay      = {cnt16, 48'd0};
        end
      end
      mie_pkg::FN_STR_HDR: begin
        if (cnt_big) begin
          cmd_nxt.op = mie_pkg::OP_COUNT_ERR;
        end else if (cnt16 <= 16'd31) begin
          cmd_nxt.op     = mie_pkg::OP_EMIT;
          cmd_nxt.is_str = 1'b1;
          cmd_nxt.id     = mie_pkg::ID_FIXSTR | {3'd0, cnt16[4:0]};
        end else begin
          cmd_nxt.op       = mie_pkg::OP_EMIT;
          cmd_nxt.is_str   = 1'b1;
          cmd_nxt.id       = mie_pkg::ID_STR16;
          cmd_nxt.has_pay  = 1'b1;
          cmd_nxt.pay_last = 3'd1;
          cmd_nxt.pay      = {cnt16, 48'd0};
        end
      end
      mie_pkg::FN_STR_BYTE: begin
        cmd_nxt.op = mie_pkg::OP_STR_BYTE;
        cmd_nxt.id = in_chan.data_byte;
      end
      default: begin
        cmd_nxt.op = mie_pkg::OP_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

`default_nettype wire

// ===== rtl/mie_fifo.sv =====
// Command queue between the front end and the back end of the encoder.
// Flop based, DEPTH entries of mie_pkg::cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module mie_fifo #(
  parameter int unsigned DEPTH = mie_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire mie_pkg::cmd_t wr_cmd,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output mie_pkg::cmd_t      rd_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mie_pkg::cmd_t     mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              push, pop;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mie_back.sv =====
// Back end of the encoder: runs the command at the queue head, checks buffer
// room per chunk, tracks write offset and string state, and drives one result
// word per cycle unless stalled, from an output register. Uses mie_pkg, mie_if.
`timescale 1ns / 1ps
`default_nettype none

module mie_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  mie_cfg_if.sink            cfg_chan,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire mie_pkg::cmd_t cmd,
  mie_out_if.source          out_chan
);

  localparam int unsigned SUM_W = mie_pkg::BUF_SIZE_W + 1;

  logic [mie_pkg::BUF_SIZE_W-1:0] buf_size_r;
  logic [mie_pkg::BUF_SIZE_W-1:0] wo_r, wo_nxt;
  logic [mie_pkg::STR_LEN_W-1:0]  left_r, left_nxt;
  logic                           fits_r, fits_nxt;
  mie_pkg::phase_t                phase_r, phase_nxt;
  logic [2:0]                     idx_r, idx_nxt;

  logic                           out_valid_r;
  logic [7:0]                     out_byte_r;
  logic [mie_pkg::OFFSET_W-1:0]   out_offset_r;
  logic                           byte_valid_r;
  mie_pkg::status_t               status_r;
  logic                           is_last_r;

  logic                           load, fire;
  logic [mie_pkg::BUF_SIZE_W-1:0] eff_size;
  logic [SUM_W-1:0]               need, pay_need, str_need;
  logic                           room_one, room_need;
  logic [5:0]                     pay_lsb;
  logic [7:0]                     pay_byte;
  logic                           hdr_final;

  logic [7:0]                     r_byte;
  logic                           r_bv;
  mie_pkg::status_t               r_status;
  logic                           r_last;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= mie_pkg::BUF_SIZE_RESET;
    end else if (cfg_chan.valid) begin
      buf_size_r <= cfg_chan.buffer_size;
    end
  end

  assign load      = !out_valid_r || out_chan.ready;
  assign fire      = cmd_valid && load;
  assign cmd_ready = fire && r_last;

  assign eff_size  = (buf_size_r > mie_pkg::BUF_SIZE_MAX) ? mie_pkg::BUF_SIZE_MAX
                                                          : buf_size_r;
  assign pay_need  = {{(SUM_W-3){1'b0}}, cmd.pay_last} + SUM_W'(1);
  assign str_need  = SUM_W'(cmd.str_len) + SUM_W'(1);
  // The first payload byte checks room for the whole payload; every other
  // step checks room for a string body behind the current byte.
  assign need      = ((phase_r == mie_pkg::PH_PAY) && (idx_r == 3'd0)) ? pay_need
                                                                        : str_need;
  assign room_one  = ({1'b0, wo_r} + SUM_W'(1)) <= {1'b0, eff_size};
  assign room_need = ({1'b0, wo_r} + need) <= {1'b0, eff_size};

  assign pay_lsb   = {3'd7 - idx_r, 3'b000};
  assign pay_byte  = cmd.pay[pay_lsb +: 8];

  // Result of this cycle for the command at the queue head.
  always_comb begin
    r_byte   = '0;
    r_bv     = 1'b0;
    r_status = mie_pkg::ST_OK;
    r_last   = 1'b1;
    unique case (phase_r)
      mie_pkg::PH_HEAD: begin
        unique case (cmd.op)
          mie_pkg::OP_COUNT_ERR: begin
            r_status = mie_pkg::ST_COUNT_BIG;
          end
          mie_pkg::OP_STR_BYTE: begin
            if (left_r == '0) begin
              r_status = mie_pkg::ST_NO_STRING;
            end else if (fits_r && room_one) begin
              r_byte = cmd.id;
              r_bv   = 1'b1;
            end else begin
              r_status = mie_pkg::ST_NO_ROOM;
            end
          end
          mie_pkg::OP_EMIT: begin
            if (!room_one) begin
              r_status = mie_pkg::ST_NO_ROOM;
            end else begin
              r_byte = cmd.id;
              r_bv   = 1'b1;
              // A fixstr header is complete here; room for its body decides
              // whether a no-room word follows.
              r_last = !cmd.has_pay && (!cmd.is_str || room_need);
            end
          end
          default: begin
          end
        endcase
      end
      mie_pkg::PH_PAY: begin
        if ((idx_r == 3'd0) && !room_need) begin
          r_status = mie_pkg::ST_NO_ROOM;
        end else begin
          r_byte = pay_byte;
          r_bv   = 1'b1;
          r_last = (idx_r == cmd.pay_last) && (!cmd.is_str || room_need);
        end
      end
      mie_pkg::PH_OPEN_FAIL: begin
        r_status = mie_pkg::ST_NO_ROOM;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    if (fire) begin
      if (r_last) begin
        phase_nxt = mie_pkg::PH_HEAD;
        idx_nxt   = '0;
      end else begin
        unique case (phase_r)
          mie_pkg::PH_HEAD: begin
            phase_nxt = cmd.has_pay ? mie_pkg::PH_PAY : mie_pkg::PH_OPEN_FAIL;
            idx_nxt   = '0;
          end
          mie_pkg::PH_PAY: begin
            if (idx_r == cmd.pay_last) begin
              phase_nxt = mie_pkg::PH_OPEN_FAIL;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          default: begin
            phase_nxt = mie_pkg::PH_HEAD;
            idx_nxt   = '0;
          end
        endcase
      end
    end
  end

  assign hdr_final = cmd.is_str && r_bv &&
                     (((phase_r == mie_pkg::PH_HEAD) && !cmd.has_pay) ||
                      ((phase_r == mie_pkg::PH_PAY) && (idx_r == cmd.pay_last)));

  always_comb begin
    wo_nxt   = wo_r;
    left_nxt = left_r;
    fits_nxt = fits_r;
    if (fire) begin
      if ((phase_r == mie_pkg::PH_HEAD) && (cmd.op == mie_pkg::OP_RESTART ||
          cmd.op == mie_pkg::OP_COUNT_ERR || cmd.op == mie_pkg::OP_EMIT)) begin
        left_nxt = '0;
        fits_nxt = 1'b0;
      end
      if ((phase_r == mie_pkg::PH_HEAD) && (cmd.op == mie_pkg::OP_RESTART)) begin
        wo_nxt = '0;
      end
      if ((phase_r == mie_pkg::PH_HEAD) && (cmd.op == mie_pkg::OP_STR_BYTE) &&
          (left_r != '0)) begin
        left_nxt = left_r - 1'b1;
      end
      if (r_bv) begin
        wo_nxt = wo_r + 1'b1;
      end
      if (hdr_final) begin
        left_nxt = cmd.str_len;
        fits_nxt = room_need;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= mie_pkg::PH_HEAD;
      idx_r       <= '0;
      wo_r        <= '0;
      left_r      <= '0;
      fits_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      wo_r    <= wo_nxt;
      left_r  <= left_nxt;
      fits_r  <= fits_nxt;
      if (load) begin
        out_valid_r <= cmd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte_r   <= r_byte;
      out_offset_r <= r_bv ? wo_r[mie_pkg::OFFSET_W-1:0] : '0;
      byte_valid_r <= r_bv;
      status_r     <= r_status;
      is_last_r    <= r_last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_byte   = out_byte_r;
  assign out_chan.out_offset = out_offset_r;
  assign out_chan.byte_valid = byte_valid_r;
  assign out_chan.status     = status_r;
  assign out_chan.is_last    = is_last_r;

endmodule

`default_nettype wire

// ===== rtl/mie_checker.sv =====
// Port level checks for the MessagePack item encoder, attached to the top
// level by the bind statement at the end. Uses mie_pkg status codes.
`timescale 1ns / 1ps
`default_nettype none

module mie_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [7:0]                   out_byte,
  input wire logic [mie_pkg::OFFSET_W-1:0] out_offset,
  input wire logic                         byte_valid,
  input wire logic [1:0]                   status,
  input wire logic                         is_last
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_offset) && $stable(byte_valid) && $stable(status) && $stable(is_last))
    else $error("result word changed while stalled");

  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_valid |-> status == mie_pkg::ST_OK)
    else $error("byte word with error status");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> out_byte == 8'd0 && out_offset == '0)
    else $error("word without byte carries data");

  // Count and missing string errors end their item at once.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == mie_pkg::ST_COUNT_BIG || status == mie_pkg::ST_NO_STRING)
      |-> is_last)
    else $error("count or string error word is not the last of its item");

endmodule

bind messagepack_item_encoder mie_checker u_mie_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_byte   (out_chan.out_byte),
  .out_offset (out_chan.out_offset),
  .byte_valid (out_chan.byte_valid),
  .status     (out_chan.status),
  .is_last    (out_chan.is_last)
);

`default_nettype wire

// ===== dv/messagepack_item_encoder_test.sv =====
// Self-checking testbench for messagepack_item_encoder.
// Needs mie_pkg and the channel interfaces from rtl/mie_if.sv. Expected words come
// from a cycle-free encoder model that is kept in step with every accepted word.
`timescale 1ns / 1ps

typedef struct packed {
  logic [7:0]  data;
  logic [19:0] offset;
  logic        has_byte;
  logic [1:0]  status;
  logic        last;
} enc_word_t;

class msgpack_byte_book;
  logic [20:0]  buf_size;
  logic [20:0]  wr_off;
  logic [15:0]  str_left;
  bit           str_fits;
  enc_word_t    owed[$];
  int unsigned  mismatches;

  function new();
    buf_size   = mie_pkg::BUF_SIZE_RESET;
    wr_off     = '0;
    str_left   = '0;
    str_fits   = 1'b0;
    mismatches = 0;
  endfunction

  function void set_buffer_size(logic [20:0] size);
    buf_size = size;
  endfunction

  function int unsigned pending();
    return owed.size();
  endfunction

  function bit fits(int unsigned len);
    int unsigned cap;
    cap = 32'((buf_size > mie_pkg::BUF_SIZE_MAX) ? mie_pkg::BUF_SIZE_MAX : buf_size);
    return (32'(wr_off) + len) <= cap;
  endfunction

  function void flag(logic [1:0] st);
    enc_word_t w;
    w = '0;
    w.status = st;
    owed.push_back(w);
  endfunction

  function void push_byte(logic [7:0] b);
    enc_word_t w;
    w          = '0;
    w.data     = b;
    w.offset   = wr_off[19:0];
    w.has_byte = 1'b1;
    w.status   = mie_pkg::ST_OK;
    owed.push_back(w);
    wr_off = wr_off + 1'b1;
  endfunction

  // A chunk goes out whole, most significant byte first, or not at all.
  function bit put_chunk(logic [63:0] be, int unsigned len);
    if (!fits(len)) begin
      flag(mie_pkg::ST_NO_ROOM);
      return 1'b0;
    end
    for (int i = int'(len) - 1; i >= 0; i--) begin
      push_byte(be[8*i +: 8]);
    end
    return 1'b1;
  endfunction

  function void id_and_value(logic [7:0] id, logic [63:0] val, int unsigned len);
    if (put_chunk(64'(id), 1)) begin
      void'(put_chunk(val, len));
    end
  endfunction

  function void header(logic [31:0] count, logic [7:0] fix_id, logic [7:0] id16);
    if (count >= 32'd65536) begin
      flag(mie_pkg::ST_COUNT_BIG);
    end else if (count <= 32'd15) begin
      void'(put_chunk(64'(fix_id | {4'd0, count[3:0]}), 1));
    end else begin
      id_and_value(id16, 64'(count), 2);
    end
  endfunction

  function void open_string(logic [31:0] count);
    if (count >= 32'd65536) begin
      flag(mie_pkg::ST_COUNT_BIG);
      return;
    end
    if (count <= 32'd31) begin
      if (!put_chunk(64'(mie_pkg::ID_FIXSTR | {3'd0, count[4:0]}), 1)) return;
    end else begin
      if (!put_chunk(64'(mie_pkg::ID_STR16), 1)) return;
      if (!put_chunk(64'(count[15:0]), 2)) return;
    end
    str_left = count[15:0];
    str_fits = fits(count);
    if (!str_fits) flag(mie_pkg::ST_NO_ROOM);
  endfunction

  function void encode_item(logic [3:0] fn, logic [63:0] value, logic [31:0] count,
                            logic [7:0] data_in);
    enc_word_t w;
    // Any defined function but a string byte closes an open string.
    if (fn <= mie_pkg::FN_STR_HDR) begin
      str_left = '0;
      str_fits = 1'b0;
    end
    case (fn)
      mie_pkg::FN_RESTART: begin
        wr_off = '0;
        flag(mie_pkg::ST_OK);
      end
      mie_pkg::FN_NIL:     void'(put_chunk(64'(mie_pkg::ID_NIL), 1));
      mie_pkg::FN_FALSE:   void'(put_chunk(64'(mie_pkg::ID_FALSE), 1));
      mie_pkg::FN_TRUE:    void'(put_chunk(64'(mie_pkg::ID_TRUE), 1));
      mie_pkg::FN_U64:     id_and_value(mie_pkg::ID_UINT64, value, 8);
      mie_pkg::FN_I64:     id_and_value(mie_pkg::ID_INT64, value, 8);
      mie_pkg::FN_F64:     id_and_value(mie_pkg::ID_FLOAT64, value, 8);
      mie_pkg::FN_MAP:     header(count, mie_pkg::ID_FIXMAP, mie_pkg::ID_MAP16);
      mie_pkg::FN_ARRAY:   header(count, mie_pkg::ID_FIXARRAY, mie_pkg::ID_ARRAY16);
      mie_pkg::FN_STR_HDR: open_string(count);
      mie_pkg::FN_STR_BYTE: begin
        if (str_left == '0) begin
          flag(mie_pkg::ST_NO_STRING);
        end else begin
          str_left = str_left - 1'b1;
          if (str_fits && fits(1)) push_byte(data_in);
          else flag(mie_pkg::ST_NO_ROOM);
        end
      end
      default: flag(mie_pkg::ST_OK);
    endcase
    w = owed.pop_back();
    w.last = 1'b1;
    owed.push_back(w);
  endfunction

  task report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task check_word(enc_word_t got);
    enc_word_t want;
    if (owed.size() == 0) begin
      report_mismatch($sformatf("unexpected word byte %02h off %0d valid %0b st %0d last %0b",
                                got.data, got.offset, got.has_byte, got.status, got.last));
      return;
    end
    want = owed.pop_front();
    if (got !== want) begin
      report_mismatch($sformatf({"byte %02h/%02h off %0d/%0d valid %0b/%0b st %0d/%0d",
                                 " last %0b/%0b (got/expected)"},
                                got.data, want.data, got.offset, want.offset,
                                got.has_byte, want.has_byte, got.status, want.status,
                                got.last, want.last));
    end
  endtask
endclass

module messagepack_item_encoder_test;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned PHASE_ITEMS   = 16;
  localparam int unsigned NUM_PHASES    = 8;
  localparam logic [3:0]  FN_UNUSED_LO  = 4'd11;
  localparam logic [3:0]  FN_UNUSED_HI  = 4'd15;
  localparam logic [20:0] PHASE_SIZES [NUM_PHASES] = '{
    21'd4096, 21'd12, 21'd30, 21'd1048576, 21'd0, 21'd2097151, 21'd64, 21'd1
  };

  logic clk;
  logic rst_n;

  mie_in_if  in_if();
  mie_out_if out_if();
  mie_cfg_if cfg_if();

  messagepack_item_encoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  msgpack_byte_book book;
  int unsigned      idle_pct;
  int unsigned      stall_pct;
  int unsigned      items_sent;
  int unsigned      holds_asked;
  int unsigned      cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** messagepack_item_encoder: FAILED **");
    $finish;
  end

  // Result side: checks every word taken and picks the next ready value.
  initial begin
    int unsigned holds_served;
    int unsigned hold_left;
    enc_word_t   got;
    holds_served = 0;
    hold_left    = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got.data     = out_if.out_byte;
        got.offset   = out_if.out_offset;
        got.has_byte = out_if.byte_valid;
        got.status   = out_if.status;
        got.last     = out_if.is_last;
        book.check_word(got);
      end
      if (hold_left == 0 && holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic logic [63:0] rand_value();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] rand_count();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2, 3, 4: return $urandom_range(70000);
      default: return $urandom_range(40);
    endcase
  endfunction

  task automatic send(logic [3:0] fn, logic [63:0] value, logic [31:0] count,
                      logic [7:0] data_in);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= fn;
    in_if.value     <= value;
    in_if.count     <= count;
    in_if.data_byte <= data_in;
    do @(posedge clk); while (!in_if.ready);
    book.encode_item(fn, value, count, data_in);
    items_sent++;
  endtask

  task automatic send_string_bytes(int unsigned n);
    repeat (n) send(mie_pkg::FN_STR_BYTE, rand_value(), rand_count(),
                    8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic write_buffer_size(logic [20:0] size);
    cfg_if.valid       <= 1'b1;
    cfg_if.buffer_size <= size;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    book.set_buffer_size(size);
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0:       begin idle_pct = 0;  stall_pct = 0;  end
      1:       begin idle_pct = 51; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 51; end
      default: begin idle_pct = 8;  stall_pct = 8;  end
    endcase
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned len;
    int unsigned body;
    pick = $urandom_range(99);
    if (pick < 30) begin
      // Mostly complete strings; some are cut short or overrun by one byte.
      len = ($urandom_range(9) == 0) ? $urandom_range(32, 60) : $urandom_range(31);
      body = len;
      if ($urandom_range(9) == 0) body = $urandom_range(len);
      else if ($urandom_range(9) == 0) body = len + 1;
      send(mie_pkg::FN_STR_HDR, rand_value(), len, 8'($urandom_range(255)));
      send_string_bytes(body);
    end else if (pick < 36) begin
      send(mie_pkg::FN_RESTART, rand_value(), rand_count(), 8'($urandom_range(255)));
    end else if (pick < 40) begin
      send(4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI)), rand_value(), rand_count(),
           8'($urandom_range(255)));
    end else begin
      send(4'($urandom_range(mie_pkg::FN_NIL, mie_pkg::FN_STR_BYTE)), rand_value(),
           rand_count(), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int unsigned target;
    book        = new();
    idle_pct    = 0;
    stall_pct   = 0;
    items_sent  = 0;
    holds_asked = 0;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.func         <= mie_pkg::FN_RESTART;
    in_if.value        <= '0;
    in_if.count        <= '0;
    in_if.data_byte    <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.buffer_size <= mie_pkg::BUF_SIZE_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset buffer size.
    send(mie_pkg::FN_NIL, '0, '0, '0);
    send(mie_pkg::FN_FALSE, '0, '0, '0);
    send(mie_pkg::FN_TRUE, '0, '0, '0);
    send(mie_pkg::FN_U64, '1, '0, '0);
    send(mie_pkg::FN_I64, 64'h8000_0000_0000_0001, '0, '0);
    send(mie_pkg::FN_F64, 64'h3FF0_0000_0000_0000, '0, '0);
    send(mie_pkg::FN_MAP, '0, 32'd15, '0);
    send(mie_pkg::FN_MAP, '0, 32'd16, '0);
    send(mie_pkg::FN_ARRAY, '0, 32'd65535, '0);
    send(mie_pkg::FN_ARRAY, '0, 32'd65536, '0);
    send(mie_pkg::FN_MAP, '0, '1, '0);
    send(mie_pkg::FN_STR_HDR, '0, 32'd3, '0);
    send(mie_pkg::FN_STR_BYTE, '0, '0, 8'h00);
    send(mie_pkg::FN_STR_BYTE, '0, '0, 8'hFF);
    send(mie_pkg::FN_STR_BYTE, '0, '0, 8'h5A);
    send(mie_pkg::FN_STR_BYTE, '0, '0, 8'h7E);
    send(mie_pkg::FN_STR_HDR, '0, 32'd40, '0);
    send(mie_pkg::FN_NIL, '0, '0, '0);
    send(mie_pkg::FN_STR_BYTE, '0, '0, 8'h11);
    send(FN_UNUSED_HI, '1, '1, 8'hFF);
    send(mie_pkg::FN_RESTART, '1, '1, 8'hFF);

    // An open string whose room disappears when the buffer shrinks.
    wait_drained();
    write_buffer_size(21'd40);
    send(mie_pkg::FN_STR_HDR, '0, 32'd20, '0);
    send_string_bytes(2);
    wait_drained();
    write_buffer_size(21'd0);
    send_string_bytes(2);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_buffer_size(PHASE_SIZES[p]);
      set_idling(p % 4);
      // Stall the result side for a while so the input backs up.
      if (p == 0 || p == 4) holds_asked++;
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_item();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("** messagepack_item_encoder: PASSED **");
    end else begin
      $display("** messagepack_item_encoder: FAILED **");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/mie_pkg.sv
rtl/mie_if.sv
rtl/mie_front.sv
rtl/mie_fifo.sv
rtl/mie_back.sv
rtl/messagepack_item_encoder.sv
rtl/mie_checker.sv
dv/messagepack_item_encoder_test.sv
